/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge of clk, outside reset.
`define BGLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition implies another in the following cycle.
`define BGLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BGLI_ASSERT(lbl, prop, msg)
`define BGLI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/bgli_pkg.sv */
// Shared types, constants and helpers of the green interpolation block.
package bgli_pkg;

  localparam int SAMPLE_W   = 17;
  localparam int GREEN_W    = 21;
  localparam int FW_W       = 13;
  localparam int FH_W       = 16;
  localparam int PAT_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 17;
  localparam int SLOT_W     = 3;
  localparam int STORE_ROWS = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_PATTERN = 2'd2;

  localparam logic [FW_W-1:0]  FW_RESET  = 13'd4096;
  localparam logic [FH_W-1:0]  FH_RESET  = 16'd4096;
  localparam logic [PAT_W-1:0] PAT_RESET = 32'd2492765332;

  localparam logic [1:0] COLOR_GREEN = 2'd1;

  // window tap positions
  localparam int TAP_C    = 0;
  localparam int TAP_L1   = 1;
  localparam int TAP_L2   = 2;
  localparam int TAP_L3   = 3;
  localparam int TAP_R1   = 4;
  localparam int TAP_R2   = 5;
  localparam int TAP_R3   = 6;
  localparam int TAP_U1   = 7;
  localparam int TAP_U2   = 8;
  localparam int TAP_U3   = 9;
  localparam int TAP_D1   = 10;
  localparam int TAP_D2   = 11;
  localparam int TAP_D3   = 12;
  localparam int NUM_TAPS = 13;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_padding;
  } in_item_t;

  typedef struct packed {
    logic signed [GREEN_W-1:0] green;
    logic                      frame_end;
  } out_item_t;

  typedef struct packed {
    logic green;
    logic ring_outer;
    logic ring_mid;
    logic frame_end;
  } site_t;

  // (s + k) mod 6 for a row slot
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] k);
    logic [SLOT_W:0] sum;
    sum = {1'b0, s} + {1'b0, k};
    if (sum >= (SLOT_W+1)'(STORE_ROWS)) begin
      sum = sum - (SLOT_W+1)'(STORE_ROWS);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

/* rtl/core/bgli_line_mem.sv */
// Line store: one write port, two registered read ports.
module bgli_line_mem #(
  parameter int DATA_W = 96,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data while the consumer stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/core/bgli_estimate.sv */
// Green estimate pipeline: gradients, Laplacian energies, direction choice.
module bgli_estimate #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [bgli_pkg::NUM_TAPS-1:0][SAMPLE_BITS-1:0] taps,
  input  bgli_pkg::site_t                             site,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output bgli_pkg::out_item_t                         out_data
);

  localparam int DW = SAMPLE_BITS + 10;

  function automatic logic signed [DW-1:0] ext(input logic [SAMPLE_BITS-1:0] v);
    return signed'({{(DW-SAMPLE_BITS){1'b0}}, v});
  endfunction

  function automatic logic signed [DW-1:0] absd(input logic signed [DW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // tap register
  logic                                            vt_r;
  logic [bgli_pkg::NUM_TAPS-1:0][SAMPLE_BITS-1:0]  taps_r;
  bgli_pkg::site_t                                 site_t_r;

  // stage A
  logic                 va_r;
  bgli_pkg::site_t      site_a_r;
  logic signed [DW-1:0] gh_a_r, gv_a_r, c8_a_r;
  logic signed [DW-1:0] rhl_a_r, rhr_a_r, rvu_a_r, rvd_a_r, hlap_a_r, vlap_a_r;
  logic signed [DW-1:0] dh1_a_r, dh2_a_r, dv1_a_r, dv2_a_r;
  logic signed [DW-1:0] gh_a_nxt, gv_a_nxt, c8_a_nxt;
  logic signed [DW-1:0] rhl_a_nxt, rhr_a_nxt, rvu_a_nxt, rvd_a_nxt, hlap_a_nxt, vlap_a_nxt;

  // stage B
  logic                 vb_r;
  bgli_pkg::site_t      site_b_r;
  logic signed [DW-1:0] gh_b_r, gv_b_r, c8_b_r, eh_b_r, ev_b_r, dh_b_r, dv_b_r;
  logic signed [DW-1:0] hsum, vsum;

  // output register
  logic                   ov_r;
  bgli_pkg::out_item_t    out_r;
  logic signed [DW-1:0]   mh, mv, sum_hv, pick;
  logic signed [DW+bgli_pkg::GREEN_W-1:0] wide;

  logic o_rdy, b_rdy, a_rdy, t_rdy;

  assign o_rdy    = !ov_r || !out_stall;
  assign b_rdy    = !vb_r || o_rdy;
  assign a_rdy    = !va_r || b_rdy;
  assign t_rdy    = !vt_r || a_rdy;
  assign in_ready = t_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (t_rdy) vt_r <= in_valid;
      if (a_rdy) va_r <= vt_r;
      if (b_rdy) vb_r <= va_r;
      if (o_rdy) ov_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (t_rdy) begin
      taps_r   <= taps;
      site_t_r <= site;
    end
  end

  // stage A: directional estimates and residual pieces
  always_comb begin
    logic signed [DW-1:0] c, l1, l2, l3, r1, r2, r3, u1, u2, u3, d1, d2, d3;
    c  = ext(taps_r[bgli_pkg::TAP_C]);
    l1 = ext(taps_r[bgli_pkg::TAP_L1]);
    l2 = ext(taps_r[bgli_pkg::TAP_L2]);
    l3 = ext(taps_r[bgli_pkg::TAP_L3]);
    r1 = ext(taps_r[bgli_pkg::TAP_R1]);
    r2 = ext(taps_r[bgli_pkg::TAP_R2]);
    r3 = ext(taps_r[bgli_pkg::TAP_R3]);
    u1 = ext(taps_r[bgli_pkg::TAP_U1]);
    u2 = ext(taps_r[bgli_pkg::TAP_U2]);
    u3 = ext(taps_r[bgli_pkg::TAP_U3]);
    d1 = ext(taps_r[bgli_pkg::TAP_D1]);
    d2 = ext(taps_r[bgli_pkg::TAP_D2]);
    d3 = ext(taps_r[bgli_pkg::TAP_D3]);
    gh_a_nxt   = ((l1 + r1) <<< 2) + (c <<< 2) - ((l2 + r2) <<< 1);
    gv_a_nxt   = ((u1 + d1) <<< 2) + (c <<< 2) - ((u2 + d2) <<< 1);
    c8_a_nxt   = c <<< 3;
    rhl_a_nxt  = (l2 <<< 3) - ((l3 + l1) <<< 2);
    rhr_a_nxt  = (r2 <<< 3) - ((r1 + r3) <<< 2);
    rvu_a_nxt  = (u2 <<< 3) - ((u3 + u1) <<< 2);
    rvd_a_nxt  = (d2 <<< 3) - ((d1 + d3) <<< 2);
    hlap_a_nxt = l2 - (c <<< 1) + r2;
    vlap_a_nxt = u2 - (c <<< 1) + d2;
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      site_a_r <= site_t_r;
      gh_a_r   <= gh_a_nxt;
      gv_a_r   <= gv_a_nxt;
      c8_a_r   <= c8_a_nxt;
      rhl_a_r  <= rhl_a_nxt;
      rhr_a_r  <= rhr_a_nxt;
      rvu_a_r  <= rvu_a_nxt;
      rvd_a_r  <= rvd_a_nxt;
      hlap_a_r <= hlap_a_nxt;
      vlap_a_r <= vlap_a_nxt;
      dh1_a_r  <= ext(taps_r[bgli_pkg::TAP_L2]) - ext(taps_r[bgli_pkg::TAP_C]);
      dh2_a_r  <= ext(taps_r[bgli_pkg::TAP_L1]) - ext(taps_r[bgli_pkg::TAP_R1]);
      dv1_a_r  <= ext(taps_r[bgli_pkg::TAP_U2]) - ext(taps_r[bgli_pkg::TAP_C]);
      dv2_a_r  <= ext(taps_r[bgli_pkg::TAP_U1]) - ext(taps_r[bgli_pkg::TAP_D1]);
    end
  end

  // stage B: energies and gradient magnitudes
  assign hsum = rhl_a_r - ((c8_a_r - gh_a_r) <<< 1) + rhr_a_r;
  assign vsum = rvu_a_r - ((c8_a_r - gv_a_r) <<< 1) + rvd_a_r;

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      site_b_r <= site_a_r;
      gh_b_r   <= gh_a_r;
      gv_b_r   <= gv_a_r;
      c8_b_r   <= c8_a_r;
      eh_b_r   <= absd(hsum) + (absd(hlap_a_r) <<< 3);
      ev_b_r   <= absd(vsum) + (absd(vlap_a_r) <<< 3);
      dh_b_r   <= absd(dh1_a_r) + absd(dh2_a_r);
      dv_b_r   <= absd(dv1_a_r) + absd(dv2_a_r);
    end
  end

  // output stage: pick direction, average on a tie (rounded toward zero)
  always_comb begin
    mh     = site_b_r.ring_mid ? dh_b_r : eh_b_r;
    mv     = site_b_r.ring_mid ? dv_b_r : ev_b_r;
    sum_hv = gh_b_r + gv_b_r;
    if (site_b_r.green) begin
      pick = c8_b_r;
    end else if (site_b_r.ring_outer) begin
      pick = '0;
    end else if (mh < mv) begin
      pick = gh_b_r;
    end else if (mv < mh) begin
      pick = gv_b_r;
    end else begin
      pick = (sum_hv + ((sum_hv < 0) ? DW'(1) : DW'(0))) >>> 1;
    end
    wide = {{bgli_pkg::GREEN_W{pick[DW-1]}}, pick};
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      out_r.green     <= wide[bgli_pkg::GREEN_W-1:0];
      out_r.frame_end <= site_b_r.frame_end;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

/* rtl/core/bayer_green_laplacian_interpolation.sv */
// Top level: Bayer green-plane interpolation with a six-row line store.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+--------------------------
//  in_     | input     | in_item_t (sample)   | in_valid / in_stall
//  out_    | output    | out_item_t (green)   | out_valid / out_stall
//  cfg_    | input     | cfg_index, cfg_data  | cfg_we, no wait
//
// One item per cycle sustained while out_stall is low; each result passes the
// line store read, tap register, two arithmetic stages and output register.
// The line store holds one word per column with six row lanes; a single
// read-modify-write per item keeps it current, so throughput is set by its
// one write port. Reset clears counters, valid bits and configuration only;
// the store and data registers need none. A stalled output only backs up as
// far as the first empty stage, so items keep coming in while bubbles remain.
module bayer_green_laplacian_interpolation #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bgli_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bgli_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [bgli_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgli_pkg::CFG_W-1:0]        cfg_data
);

`include "assert_macros.svh"

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = AW + 1;
  localparam int WORDW = bgli_pkg::STORE_ROWS * SAMPLE_BITS;
  localparam int SW    = bgli_pkg::SLOT_W;
  localparam int RW    = bgli_pkg::ROW_W;

  // configuration registers
  logic [bgli_pkg::FW_W-1:0]  fw_r;
  logic [bgli_pkg::FH_W-1:0]  fh_r;
  logic [bgli_pkg::PAT_W-1:0] pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= bgli_pkg::FW_RESET;
      fh_r  <= bgli_pkg::FH_RESET;
      pat_r <= bgli_pkg::PAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bgli_pkg::CFG_FRAME_WIDTH:   fw_r  <= cfg_data[bgli_pkg::FW_W-1:0];
        bgli_pkg::CFG_FRAME_HEIGHT:  fh_r  <= cfg_data[bgli_pkg::FH_W-1:0];
        bgli_pkg::CFG_COLOR_PATTERN: pat_r <= cfg_data[bgli_pkg::PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated frame size
  logic [31:0]   fw32, w32;
  logic [CW-1:0] w_eff, w_last;
  logic [bgli_pkg::FH_W-1:0] h_eff;

  assign fw32   = {{(32-bgli_pkg::FW_W){1'b0}}, fw_r};
  assign w32    = (fw32 < 32'd8) ? 32'd8 :
                  (fw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw32;
  assign w_eff  = w32[CW-1:0];
  assign w_last = w_eff - CW'(1);
  assign h_eff  = (fh_r < 16'd8) ? 16'd8 : fh_r;

  // input position
  logic [AW-1:0] col_r, col_e, col_nxt;
  logic [RW-1:0] row_r, row_e, row_nxt, row_inc, row_end;
  logic [SW-1:0] slot_r, slot_e, slot_nxt;
  logic          restart, real_row, drop, accept, acc_keep, emit0, last_col;

  logic s1_rdy, t_rdy;

  assign row_end  = {1'b0, h_eff} + RW'(3);
  assign restart  = ({1'b0, col_r} >= w_eff) || (row_r >= row_end);
  assign col_e    = restart ? '0 : col_r;
  assign row_e    = restart ? '0 : row_r;
  assign slot_e   = restart ? '0 : slot_r;
  assign real_row = row_e < {1'b0, h_eff};
  assign drop     = real_row && in_data.is_padding;
  assign accept   = in_valid && s1_rdy;
  assign acc_keep = accept && !drop;
  assign in_stall = !s1_rdy;
  assign emit0    = row_e >= RW'(3);
  assign last_col = {1'b0, col_e} == w_last;
  assign row_inc  = row_e + RW'(1);

  always_comb begin
    col_nxt  = col_e;
    row_nxt  = row_e;
    slot_nxt = slot_e;
    if (!drop) begin
      if (last_col) begin
        col_nxt = '0;
        if (row_inc >= row_end) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_inc;
          slot_nxt = bgli_pkg::slot_add(slot_e, SW'(1));
        end
      end else begin
        col_nxt = col_e + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // clamp the sample; flush rows write zero
  logic [SAMPLE_BITS+15:0] raw_ext, max_ext;
  logic [SAMPLE_BITS-1:0]  cur0;

  assign raw_ext = {{SAMPLE_BITS{1'b0}}, in_data.sample[15:0]};
  assign max_ext = {16'd0, {SAMPLE_BITS{1'b1}}};

  always_comb begin
    if (!real_row || in_data.sample[16]) begin
      cur0 = '0;
    end else if (raw_ext > max_ext) begin
      cur0 = {SAMPLE_BITS{1'b1}};
    end else begin
      cur0 = raw_ext[SAMPLE_BITS-1:0];
    end
  end

  // site class of the output pixel (row - 3, column)
  logic [bgli_pkg::FH_W-1:0] oy;
  logic [CW-1:0]             ox;
  logic [1:0]                color;
  bgli_pkg::site_t           site0;

  assign oy    = row_e[bgli_pkg::FH_W-1:0] - 16'd3;
  assign ox    = {1'b0, col_e};
  assign color = pat_r[{oy[2:0], col_e[0], 1'b0} +: 2];

  always_comb begin
    site0.green      = color == bgli_pkg::COLOR_GREEN;
    site0.ring_outer = (oy < 16'd2) || (oy >= h_eff - 16'd2) ||
                       (ox < CW'(2)) || (ox >= w_eff - CW'(2));
    site0.ring_mid   = (oy < 16'd4) || (oy >= h_eff - 16'd4) ||
                       (ox < CW'(4)) || (ox >= w_eff - CW'(4));
    site0.frame_end  = (oy == h_eff - 16'd1) && (ox == w_last);
  end

  // line store
  logic             mem_we;
  logic [WORDW-1:0] rd_a, rd_b, wr_word;

  // stage 1: read data arrives
  logic                   v1_r, emit1_r;
  logic [AW-1:0]          col1_r;
  logic [SW-1:0]          slot1_r;
  logic [SAMPLE_BITS-1:0] cur1_r;
  bgli_pkg::site_t        site1_r;
  logic                   adv1;

  assign s1_rdy = !v1_r || t_rdy;
  assign adv1   = v1_r && t_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_rdy) begin
      v1_r <= acc_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      emit1_r <= emit0;
      col1_r  <= col_e;
      slot1_r <= slot_e;
      cur1_r  <= cur0;
      site1_r <= site0;
    end
  end

  bgli_line_mem #(
    .DATA_W (WORDW),
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (AW)
  ) u_line_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (col1_r),
    .wdata   (wr_word),
    .re      (s1_rdy),
    .raddr_a (col_e),
    .raddr_b (col_e + AW'(3)),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // replace the oldest row's lane with the incoming sample
  assign mem_we = adv1;

  always_comb begin
    wr_word = rd_a;
    wr_word[slot1_r*SAMPLE_BITS +: SAMPLE_BITS] = cur1_r;
  end

  // lanes: slot holds row-6 (read before overwrite), slot+3 is the center row
  logic [SW-1:0] sc, su1, su2, sd1, sd2;
  logic [SAMPLE_BITS-1:0] a_c, b_c;
  logic [SAMPLE_BITS-1:0] lh0_r, lh1_r, lh2_r, rb0_r, rb1_r;
  logic [bgli_pkg::NUM_TAPS-1:0][SAMPLE_BITS-1:0] taps;

  assign sc  = bgli_pkg::slot_add(slot1_r, SW'(3));
  assign su1 = bgli_pkg::slot_add(slot1_r, SW'(2));
  assign su2 = bgli_pkg::slot_add(slot1_r, SW'(1));
  assign sd1 = bgli_pkg::slot_add(slot1_r, SW'(4));
  assign sd2 = bgli_pkg::slot_add(slot1_r, SW'(5));
  assign a_c = rd_a[sc*SAMPLE_BITS +: SAMPLE_BITS];
  assign b_c = rd_b[sc*SAMPLE_BITS +: SAMPLE_BITS];

  // center row history: left taps from earlier column reads, right taps
  // from earlier look-ahead reads
  always_ff @(posedge clk) begin
    if (adv1) begin
      lh0_r <= a_c;
      lh1_r <= lh0_r;
      lh2_r <= lh1_r;
      rb0_r <= b_c;
      rb1_r <= rb0_r;
    end
  end

  always_comb begin
    taps[bgli_pkg::TAP_C]  = a_c;
    taps[bgli_pkg::TAP_L1] = lh0_r;
    taps[bgli_pkg::TAP_L2] = lh1_r;
    taps[bgli_pkg::TAP_L3] = lh2_r;
    taps[bgli_pkg::TAP_R1] = rb1_r;
    taps[bgli_pkg::TAP_R2] = rb0_r;
    taps[bgli_pkg::TAP_R3] = b_c;
    taps[bgli_pkg::TAP_U1] = rd_a[su1*SAMPLE_BITS +: SAMPLE_BITS];
    taps[bgli_pkg::TAP_U2] = rd_a[su2*SAMPLE_BITS +: SAMPLE_BITS];
    taps[bgli_pkg::TAP_U3] = rd_a[slot1_r*SAMPLE_BITS +: SAMPLE_BITS];
    taps[bgli_pkg::TAP_D1] = rd_a[sd1*SAMPLE_BITS +: SAMPLE_BITS];
    taps[bgli_pkg::TAP_D2] = rd_a[sd2*SAMPLE_BITS +: SAMPLE_BITS];
    taps[bgli_pkg::TAP_D3] = cur1_r;
  end

  bgli_estimate #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_estimate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r && emit1_r),
    .in_ready  (t_rdy),
    .taps      (taps),
    .site      (site1_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // wrap the column after the last pixel of a row
  `BGLI_ASSERT_NEXT(a_col_wrap, acc_keep && last_col, col_r == '0, "column did not wrap")
  // row zero always maps to slot zero
  `BGLI_ASSERT(a_slot_row0, (row_r == '0) |-> (slot_r == '0), "row slot out of step")
  // every kept item reaches the read stage
  `BGLI_ASSERT_NEXT(a_keep_s1, acc_keep, v1_r, "accepted item lost before read stage")

endmodule
